// File: rtl/dnas_pkg.sv
// package for the depth normal angle stream
// constants, cordic angle table and shared types; no dependencies
`timescale 1ns / 1ps
package dnas_pkg;

  localparam int unsigned MaxLineDef   = 2048;
  localparam int unsigned AngleBitsDef = 16;
  localparam int unsigned CordicSteps  = 30;
  localparam int unsigned PreShift     = 20;
  localparam int unsigned DepthW       = 16;
  localparam int unsigned CfgW         = 12;
  localparam int unsigned StepW        = 5;
  // cordic datapath width: operands below 2^22 shifted by 20, plus growth and sign
  localparam int unsigned CorW         = 46;
  localparam int unsigned AngW         = 34;
  localparam logic [CfgW-1:0] LineWidthRst = 12'd1024;

  // work item handed from front to back
  typedef struct packed {
    logic [DepthW:0] x_abs;
    logic [DepthW:0] y_abs;
    logic            x_neg;
    logic            y_neg;
    logic            valid;
  } work_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [StepW-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/dnas_front.sv
// front part: line store, left pixel, column tracking and difference forming
// depends on dnas_pkg
`timescale 1ns / 1ps
module dnas_front #(
  parameter int unsigned MaxLine = dnas_pkg::MaxLineDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dnas_pkg::CfgW-1:0]    line_width_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dnas_pkg::DepthW-1:0]  depth_sample_i,
  input  logic                         frame_start_i,
  output logic                         wk_valid_o,
  input  logic                         wk_stall_i,
  output dnas_pkg::work_t              wk_o
);
  import dnas_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxLine);
  localparam int unsigned ColW = IdxW + 1;

  logic [DepthW-1:0] mem_q [MaxLine];
  logic [DepthW-1:0] top_q, ctr_q, left_q, left_d;
  logic [DepthW-1:0] left_q_s1;
  logic [ColW-1:0]   col_q, col_d, col_use, col_inc;
  logic              past_q, past_d, past_use;
  logic              s1_valid_q, s1_nv_q;
  logic              out_valid_q;
  work_t             out_q;
  logic [ColW-1:0]   eff_w;
  logic              acc, s1_move, out_free;

  assign out_free   = !out_valid_q || !wk_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign acc        = in_valid_i && !in_stall_o;

  // effective line width, clamped
  always_comb begin
    priority if (line_width_i < CfgW'(2)) eff_w = ColW'(2);
    else if (32'(line_width_i) > MaxLine) eff_w = ColW'(MaxLine);
    else eff_w = ColW'(line_width_i);
  end

  // column and row flag update
  always_comb begin
    col_use  = frame_start_i ? '0 : col_q;
    past_use = frame_start_i ? 1'b0 : past_q;
    col_inc  = col_use + ColW'(1);
    col_d    = col_q;
    past_d   = past_q;
    left_d   = left_q;
    if (acc) begin
      left_d = depth_sample_i;
      if (col_inc >= eff_w) begin
        col_d  = '0;
        past_d = 1'b1;
      end else begin
        col_d  = col_inc;
        past_d = past_use;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      past_q      <= 1'b0;
      left_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      past_q <= past_d;
      left_q <= left_d;
      if (acc) s1_valid_q <= 1'b1;
      else if (s1_move) s1_valid_q <= 1'b0;
      if (s1_move) out_valid_q <= 1'b1;
      else if (!wk_stall_i) out_valid_q <= 1'b0;
    end
  end

  // line store read and write in one port cycle
  always_ff @(posedge clk_i) begin
    if (acc) begin
      top_q <= mem_q[col_use[IdxW-1:0]];
      mem_q[col_use[IdxW-1:0]] <= depth_sample_i;
      ctr_q   <= depth_sample_i;
      s1_nv_q <= past_use && (col_use != '0);
    end
  end

  // differences to the output register
  logic signed [DepthW+1:0] xs, ys;
  always_comb begin
    xs = $signed({2'b00, ctr_q}) - $signed({2'b00, left_q_s1});
    ys = $signed({2'b00, ctr_q}) - $signed({2'b00, top_q});
  end

  always_ff @(posedge clk_i) begin
    if (acc) left_q_s1 <= left_q;
    if (s1_move) begin
      out_q.x_neg <= xs[DepthW+1];
      out_q.y_neg <= ys[DepthW+1];
      out_q.x_abs <= xs[DepthW+1] ? (DepthW+1)'(-xs) : xs[DepthW:0];
      out_q.y_abs <= ys[DepthW+1] ? (DepthW+1)'(-ys) : ys[DepthW:0];
      out_q.valid <= s1_nv_q;
    end
  end

  assign wk_valid_o = out_valid_q;
  assign wk_o       = out_q;

endmodule

// File: rtl/dnas_fifo.sv
// short queue between the front and the back part
// depends on dnas_pkg
`timescale 1ns / 1ps
module dnas_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_stall_o,
  input  dnas_pkg::work_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_stall_i,
  output dnas_pkg::work_t rd_data_o
);
  import dnas_pkg::*;

  work_t       buf_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        wp_q, rp_q;
  logic        wr, rd;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;
  assign rd_data_o = buf_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) cnt_d = cnt_q + 2'd1;
    else if (rd && !wr) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) buf_q[wp_q] <= wr_data_i;
  end

endmodule

// File: rtl/dnas_back.sv
// back part: integer square root, two cordic passes on one shared unit, rounding
// depends on dnas_pkg
`timescale 1ns / 1ps
module dnas_back #(
  parameter int unsigned AngleBits = dnas_pkg::AngleBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wk_valid_i,
  output logic                  wk_stall_o,
  input  dnas_pkg::work_t       wk_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [AngleBits-1:0]  azimuth_frac_o,
  output logic [AngleBits-1:0]  elevation_frac_o,
  output logic                  normal_valid_o
);
  import dnas_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQRT = 5'b00010,
    ST_AZ   = 5'b00100,
    ST_EL   = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  localparam int unsigned SqW  = 42;  // (x^2+y^2)<<8 < 2^42
  localparam int unsigned RtW  = 21;
  localparam int unsigned PrW  = 2 * (DepthW + 1);
  localparam logic [RtW-1:0] ElX = RtW'(65535 * 16);
  localparam logic [AngW-1:0] Half = AngW'(64'h80000000);
  localparam logic [AngW-1:0] Full = AngW'(64'h100000000);
  localparam logic [AngW-1:0] Quart = AngW'(64'h40000000);
  localparam logic [AngW-1:0] RndK = AngW'(64'h1) << (31 - AngleBits);
  localparam logic [AngleBits-1:0] AMax = '1;

  state_e state_q, state_d;
  work_t  w_q;
  logic [StepW-1:0] step_q;
  logic [SqW-1:0] rem_q;
  logic [RtW-1:0] res_q;
  logic signed [CorW-1:0] cx_q, cy_q;
  logic signed [AngW-1:0] cz_q;
  logic [AngleBits-1:0] az_q, el_q;
  logic nv_q, ovalid_q;
  logic take;

  assign wk_stall_o = (state_q != ST_IDLE);
  assign take = wk_valid_i && !wk_stall_o;

  // squared magnitude of the incoming differences
  logic [PrW-1:0] xsq, ysq;
  logic [SqW-1:0] sq_in;
  always_comb begin
    xsq   = wk_i.x_abs * wk_i.x_abs;
    ysq   = wk_i.y_abs * wk_i.y_abs;
    sq_in = (SqW'(xsq) + SqW'(ysq)) << 8;
  end

  // sqrt step: one result bit per cycle
  logic [SqW:0] trial;
  logic [RtW-1:0] res_n;
  logic [SqW-1:0] rem_n;
  always_comb begin
    trial = {1'b0, rem_q} - (((SqW+1)'(res_q) << ({1'b0, step_q} + 6'd1))
                             + ((SqW+1)'(1) << {step_q, 1'b0}));
    if (!trial[SqW]) begin
      rem_n = trial[SqW-1:0];
      res_n = res_q | (RtW'(1) << step_q);
    end else begin
      rem_n = rem_q;
      res_n = res_q;
    end
  end

  // shared cordic step
  logic signed [CorW-1:0] sx, sy, nx, ny;
  logic signed [AngW-1:0] nz, zc;
  always_comb begin
    sx = cx_q >>> step_q;
    sy = cy_q >>> step_q;
    if (!cy_q[CorW-1]) begin
      nx = cx_q + sy;
      ny = cy_q - sx;
      nz = cz_q + $signed({2'b00, atan_turn(step_q)});
    end else begin
      nx = cx_q - sy;
      ny = cy_q + sx;
      nz = cz_q - $signed({2'b00, atan_turn(step_q)});
    end
    if (nz[AngW-1]) zc = '0;
    else if (nz > $signed(Quart)) zc = $signed(Quart);
    else zc = nz;
  end

  // rounding of turn values
  logic [AngW-1:0] t_az, t_el, r_az, r_el;
  logic zero_vec;
  always_comb begin
    zero_vec = (w_q.x_abs == '0) && (w_q.y_abs == '0);
    unique case ({w_q.x_neg, w_q.y_neg})
      2'b00:   t_az = zc;
      2'b10:   t_az = Half - zc;
      2'b11:   t_az = Half + zc;
      default: t_az = Full - zc;
    endcase
    t_el = Half + (zc <<< 1);
    r_az = (t_az + RndK) >> (32 - AngleBits);
    r_el = (t_el + RndK) >> (32 - AngleBits);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take) state_d = wk_i.valid ? ST_SQRT : ST_DONE;
      ST_SQRT: if (step_q == '0) state_d = ST_AZ;
      ST_AZ:   if (step_q == StepW'(CordicSteps - 1)) state_d = ST_EL;
      ST_EL:   if (step_q == StepW'(CordicSteps - 1)) state_d = ST_DONE;
      ST_DONE: if (!ovalid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && (!ovalid_q || !out_stall_i)) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        w_q    <= wk_i;
        step_q <= StepW'(RtW - 1);
        res_q  <= '0;
        rem_q  <= sq_in;
        az_q   <= '0;
        el_q   <= '0;
        nv_q   <= wk_i.valid;
      end
      ST_SQRT: begin
        rem_q <= rem_n;
        res_q <= res_n;
        if (step_q == '0) begin
          step_q <= '0;
          cx_q <= $signed(CorW'(w_q.x_abs) << PreShift);
          cy_q <= $signed(CorW'(w_q.y_abs) << PreShift);
          cz_q <= '0;
        end else begin
          step_q <= step_q - StepW'(1);
        end
      end
      ST_AZ: begin
        if (step_q == StepW'(CordicSteps - 1)) begin
          az_q   <= zero_vec ? '0 : r_az[AngleBits-1:0];
          step_q <= '0;
          cx_q <= $signed(CorW'(ElX) << PreShift);
          cy_q <= $signed(CorW'(res_q) << PreShift);
          cz_q <= '0;
        end else begin
          cx_q <= nx; cy_q <= ny; cz_q <= nz;
          step_q <= step_q + StepW'(1);
        end
      end
      ST_EL: begin
        cx_q <= nx; cy_q <= ny; cz_q <= nz;
        if (step_q == StepW'(CordicSteps - 1))
          el_q <= (r_el > AngW'(AMax)) ? AMax : r_el[AngleBits-1:0];
        else
          step_q <= step_q + StepW'(1);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // output register
  logic [AngleBits-1:0] oaz_q, oel_q;
  logic onv_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!ovalid_q || !out_stall_i)) begin
      oaz_q <= az_q;
      oel_q <= el_q;
      onv_q <= nv_q;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign azimuth_frac_o   = oaz_q;
  assign elevation_frac_o = oel_q;
  assign normal_valid_o   = onv_q;

endmodule

// File: rtl/depth_normal_angle_stream.sv
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o   depth_sample_i, frame_start_i
// out       output     out_valid_o/out_stall_i azimuth_frac_o, elevation_frac_o, normal_valid_o
// cfg       input      cfg_we_i                cfg_wdata_i (line_width)
//
// a pixel with both neighbours is taken by the back part, runs 21 square root
// steps and two 30-step cordic passes on one shared unit, then is handed off.
// border pixels skip the square root and cordic passes. the front takes one pixel
// per cycle unless stalled, into a 2-entry queue. reset clears control state;
// the line store has no reset. output stalls hold the result register and back
// up through the queue.
// top level; depends on dnas_pkg, dnas_front, dnas_fifo, dnas_back
`timescale 1ns / 1ps
module depth_normal_angle_stream #(
  parameter int unsigned MaxLine   = dnas_pkg::MaxLineDef,
  parameter int unsigned AngleBits = dnas_pkg::AngleBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dnas_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dnas_pkg::DepthW-1:0] depth_sample_i,
  input  logic                        frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [AngleBits-1:0]        azimuth_frac_o,
  output logic [AngleBits-1:0]        elevation_frac_o,
  output logic                        normal_valid_o
);
  import dnas_pkg::*;

  logic [CfgW-1:0] lw_q;
  logic  f_valid, f_stall, b_valid, b_stall;
  work_t f_data, b_data;

  // line width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lw_q <= LineWidthRst;
    else if (cfg_we_i) lw_q <= cfg_wdata_i;
  end

  dnas_front #(.MaxLine(MaxLine)) u_front (
    .clk_i, .rst_ni, .line_width_i(lw_q),
    .in_valid_i, .in_stall_o, .depth_sample_i, .frame_start_i,
    .wk_valid_o(f_valid), .wk_stall_i(f_stall), .wk_o(f_data)
  );

  dnas_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_data),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_data)
  );

  dnas_back #(.AngleBits(AngleBits)) u_back (
    .clk_i, .rst_ni,
    .wk_valid_i(b_valid), .wk_stall_o(b_stall), .wk_i(b_data),
    .out_valid_o, .out_stall_i, .azimuth_frac_o, .elevation_frac_o, .normal_valid_o
  );

endmodule

// File: rtl/dnas_checker.sv
// port-level checks for the depth normal angle stream
// depends on depth_normal_angle_stream ports only
`timescale 1ns / 1ps
module dnas_checker #(
  parameter int unsigned AngleBits = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [AngleBits-1:0] azimuth_frac_o,
  input logic [AngleBits-1:0] elevation_frac_o,
  input logic                 normal_valid_o
);

  // a stalled result holds its valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("valid dropped");

  // border pixels give zero angles
  a_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !normal_valid_o |-> azimuth_frac_o == '0 && elevation_frac_o == '0)
    else $error("border result not zero");

  // elevation of a real normal is at least one half
  a_elev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && normal_valid_o |-> elevation_frac_o[AngleBits-1])
    else $error("elevation below half");

endmodule

bind depth_normal_angle_stream dnas_checker #(.AngleBits(AngleBits)) u_dnas_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i,
  .azimuth_frac_o, .elevation_frac_o, .normal_valid_o
);

// File: verif/tb_top.sv
// self-checking testbench for depth_normal_angle_stream
// depends on dnas_pkg and the rtl top level; predicts each angle pair in place
`timescale 1ns / 1ps
module tb_top;
  import dnas_pkg::*;

  localparam int unsigned AngleBits = AngleBitsDef;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic [AngleBits-1:0] azimuth;
    logic [AngleBits-1:0] elevation;
    logic                 normal_ok;
  } angles_t;

  // directed row: either a line width write or one pixel with optional typed result
  typedef struct {
    bit                  is_width;
    logic [CfgW-1:0]     width;
    logic [DepthW-1:0]   depth;
    logic                fs;
    bit                  typed;
    angles_t             want;
  } dir_row_t;

  typedef struct {
    int unsigned     width;
    int unsigned     count;
    int unsigned     idle_pct;
    int unsigned     stall_pct;
    bit              hold;
  } phase_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CfgW-1:0]       cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [DepthW-1:0]     depth_in;
  logic                  fs_in;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [AngleBits-1:0]  azimuth_out;
  logic [AngleBits-1:0]  elevation_out;
  logic                  normal_ok_out;

  // predictor state
  logic [DepthW-1:0] row_above [MaxLineDef];
  logic [DepthW-1:0] left_px;
  int unsigned       col;
  bit                past_row0;
  int unsigned       cur_width;

  angles_t     angle_q[$];
  bit          typed_q[$];
  angles_t     typed_val_q[$];
  int unsigned err_count = 0;
  int unsigned cycles = 0;
  int unsigned stall_pct;
  int unsigned hold_left = 0;
  bit          hold_taken = 1'b0;
  bit          hold_req;

  depth_normal_angle_stream i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .depth_sample_i   (depth_in),
    .frame_start_i    (fs_in),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .azimuth_frac_o   (azimuth_out),
    .elevation_frac_o (elevation_out),
    .normal_valid_o   (normal_ok_out)
  );

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // first-quadrant angle in 2^-32 turn, floor shifts on negatives
  function automatic longint vector_angle(longint x, longint y);
    longint xi, yi, z, nx;
    xi = x <<< PreShift;
    yi = y <<< PreShift;
    z = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (yi >= 0) begin
        nx = xi + (yi >>> i);
        yi = yi - (xi >>> i);
        z += longint'(atan_turn(i[StepW-1:0]));
      end else begin
        nx = xi - (yi >>> i);
        yi = yi + (xi >>> i);
        z -= longint'(atan_turn(i[StepW-1:0]));
      end
      xi = nx;
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) <<< 30)) z = longint'(1) <<< 30;
    return z;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint rem, res, b;
    rem = v;
    res = 0;
    b = longint'(1) <<< 62;
    while (b > rem) b = b >>> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint turn_to_frac(longint t);
    return (t + (longint'(1) <<< (31 - AngleBits))) >>> (32 - AngleBits);
  endfunction

  // advance the pixel model by one transaction and return its angles
  function automatic angles_t predict_angles(logic [DepthW-1:0] c, logic fs);
    angles_t r;
    int unsigned w;
    logic [DepthW-1:0] top;
    longint xs, ys, ax, ay, a, t, h, el;
    w = cur_width;
    if (w < 2) w = 2;
    if (w > MaxLineDef) w = MaxLineDef;
    if (fs) begin
      col = 0;
      past_row0 = 1'b0;
    end
    top = row_above[col];
    r = '0;
    if (past_row0 && col != 0) begin
      xs = longint'(c) - longint'(left_px);
      ys = longint'(c) - longint'(top);
      ax = xs < 0 ? -xs : xs;
      ay = ys < 0 ? -ys : ys;
      if (ax != 0 || ay != 0) begin
        a = vector_angle(ax, ay);
        if (xs >= 0 && ys >= 0) t = a;
        else if (xs < 0 && ys >= 0) t = (longint'(1) <<< 31) - a;
        else if (xs < 0) t = (longint'(1) <<< 31) + a;
        else t = (longint'(1) <<< 32) - a;
        r.azimuth = AngleBits'(turn_to_frac(t));
      end
      h = int_sqrt((ax * ax + ay * ay) <<< 8);
      el = turn_to_frac((longint'(1) <<< 31) + 2 * vector_angle(longint'(65535) <<< 4, h));
      if (el > (longint'(1) <<< AngleBits) - 1) el = (longint'(1) <<< AngleBits) - 1;
      r.elevation = AngleBits'(el);
      r.normal_ok = 1'b1;
    end
    row_above[col] = c;
    left_px = c;
    col++;
    if (col >= w) begin
      col = 0;
      past_row0 = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // input and output transactions, sampled at the rising edge
  always @(posedge clk) begin
    angles_t exp_a;
    angles_t pred;
    if (rst_n && in_valid && !in_stall) begin
      pred = predict_angles(depth_in, fs_in);
      if (typed_q.pop_front()) exp_a = typed_val_q.pop_front();
      else exp_a = pred;
      angle_q = {angle_q, exp_a};
    end
    if (rst_n && out_valid && !out_stall) begin
      if (angle_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(azimuth_out), 32'hx);
      end else begin
        exp_a = angle_q.pop_front();
        if (azimuth_out !== exp_a.azimuth)
          report_mismatch("azimuth", 32'(azimuth_out), 32'(exp_a.azimuth));
        if (elevation_out !== exp_a.elevation)
          report_mismatch("elevation", 32'(elevation_out), 32'(exp_a.elevation));
        if (normal_ok_out !== exp_a.normal_ok)
          report_mismatch("normal valid", 32'(normal_ok_out), 32'(exp_a.normal_ok));
      end
    end
  end

  // receiver stalls, with an optional long hold counted here
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = $urandom_range(99) < stall_pct;
    end
  end

  // one pixel transaction, held until taken
  task automatic send_pixel(logic [DepthW-1:0] d, logic fs, int unsigned idle_pct,
                            bit typed, angles_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    typed_q = {typed_q, typed};
    if (typed) typed_val_q = {typed_val_q, want};
    in_valid = 1'b1;
    depth_in = d;
    fs_in = fs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // line width write once every result has been drained
  task automatic write_width(logic [CfgW-1:0] w);
    while (angle_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = w;
    cur_width = w;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [DepthW-1:0] next_depth(logic [DepthW-1:0] prev);
    int unsigned mode;
    int          v;
    mode = $urandom_range(99);
    if (mode < 60) begin
      v = int'(prev) + int'($urandom_range(512)) - 256;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return DepthW'(v);
    end
    if (mode < 75) return DepthW'($urandom);
    if (mode < 85) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return prev;
  endfunction

  dir_row_t dir_rows[] = '{
    '{0, 0, 16'd1234, 1, 1, '{0, 0, 0}},
    '{0, 0, 16'd0,    0, 1, '{0, 0, 0}},
    '{0, 0, 16'hFFFF, 0, 1, '{0, 0, 0}},
    '{1, 12'd2, 0, 0, 0, '{0, 0, 0}},
    '{0, 0, 16'd5,    1, 1, '{0, 0, 0}},
    '{0, 0, 16'd5,    0, 1, '{0, 0, 0}},
    '{0, 0, 16'd5,    0, 1, '{0, 0, 0}},
    '{0, 0, 16'd5,    0, 1, '{16'h0000, 16'h8000, 1}},
    '{0, 0, 16'd0,    0, 0, '{0, 0, 0}},
    '{0, 0, 16'hFFFF, 0, 0, '{0, 0, 0}},
    '{0, 0, 16'hFFFF, 0, 0, '{0, 0, 0}},
    '{0, 0, 16'd0,    0, 0, '{0, 0, 0}},
    '{0, 0, 16'd0,    0, 0, '{0, 0, 0}},
    '{0, 0, 16'd0,    0, 0, '{0, 0, 0}},
    '{0, 0, 16'd7,    0, 1, '{0, 0, 0}},
    '{0, 0, 16'd9,    1, 1, '{0, 0, 0}},
    '{0, 0, 16'd9,    0, 1, '{0, 0, 0}},
    '{0, 0, 16'd9,    0, 1, '{0, 0, 0}},
    '{0, 0, 16'hFFFF, 0, 0, '{0, 0, 0}}
  };

  phase_t phases[] = '{
    '{3,    250, 0,  0,  0},
    '{17,   300, 60, 0,  0},
    '{1,    200, 0,  60, 1},
    '{64,   300, 16, 16, 0},
    '{2048, 300, 0,  0,  0},
    '{4095, 40,  0,  0,  0},
    '{0,    100, 16, 16, 0},
    '{9,    150, 0,  60, 0}
  };

  // stimulus and end of run
  initial begin
    logic [DepthW-1:0] d;
    angles_t none;
    none = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    depth_in = '0;
    fs_in = 1'b0;
    stall_pct = 0;
    hold_req = 1'b0;
    left_px = '0;
    col = 0;
    past_row0 = 1'b0;
    cur_width = LineWidthRst;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_width) write_width(dir_rows[i].width);
      else send_pixel(dir_rows[i].depth, dir_rows[i].fs, 0, dir_rows[i].typed, dir_rows[i].want);
    end

    // each setting starts a new frame so no unwritten line entry is read
    d = 16'd30000;
    foreach (phases[p]) begin
      write_width(phases[p].width[CfgW-1:0]);
      stall_pct = phases[p].stall_pct;
      for (int n = 0; n < phases[p].count; n++) begin
        if (phases[p].hold && n == 20) hold_req = 1'b1;
        d = next_depth(d);
        send_pixel(d, n == 0 || $urandom_range(199) == 0, phases[p].idle_pct, 0, none);
      end
      stall_pct = 0;
    end

    while (angle_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dnas_pkg.sv
rtl/dnas_front.sv
rtl/dnas_fifo.sv
rtl/dnas_back.sv
rtl/depth_normal_angle_stream.sv
rtl/dnas_checker.sv
verif/tb_top.sv
